@@ sv/owbm_pkg.sv @@
// Package with the shared types, codes and helpers of the one-wire bus master.
`default_nettype none

package owbm_pkg;

	// Widths of the configuration port.
	localparam int unsigned CfgIndexW = 3;
	localparam int unsigned CfgDataW  = 10;

	// Configuration register indexes.
	typedef enum logic [CfgIndexW-1:0] {
		CFG_RESET_LOW      = 3'd0,
		CFG_RESPONSE_WAIT  = 3'd1,
		CFG_PRESENCE_WIN   = 3'd2,
		CFG_SLOT           = 3'd3,
		CFG_START          = 3'd4,
		CFG_SAMPLE_DELAY   = 3'd5,
		CFG_RECOVERY       = 3'd6
	} cfg_index_t;

	// Register values after reset.
	localparam logic [9:0] ResetLowDefault      = 10'd480;
	localparam logic [7:0] ResponseWaitDefault  = 8'd14;
	localparam logic [9:0] PresenceWinDefault   = 10'd240;
	localparam logic [7:0] SlotDefault          = 8'd60;
	localparam logic [3:0] StartDefault         = 4'd2;
	localparam logic [5:0] SampleDelayDefault   = 6'd5;
	localparam logic [3:0] RecoveryDefault      = 4'd2;

	// Bus commands.
	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_RESET = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	// Sequencer phases, one-hot.
	typedef enum logic [8:0] {
		PH_IDLE      = 9'b000000001,
		PH_RST_LOW   = 9'b000000010,
		PH_RST_WAIT  = 9'b000000100,
		PH_RST_WATCH = 9'b000001000,
		PH_RST_REC   = 9'b000010000,
		PH_SLOT_LOW  = 9'b000100000,
		PH_READ_WAIT = 9'b001000000,
		PH_SLOT_DATA = 9'b010000000,
		PH_SLOT_REC  = 9'b100000000
	} phase_t;

	// One tick with its optional command.
	typedef struct packed {
		logic [1:0] command;
		logic [7:0] write_data;
		logic       line_level;
	} owbm_in_t;

	// Line controls and status for one tick.
	typedef struct packed {
		logic       drive_low;
		logic       pullup_on;
		logic       busy_res;
		logic       done_res;
		logic       presence;
		logic [7:0] read_data;
	} owbm_out_t;

	// True on the last tick of a phase of the given length.
	function automatic logic at_end(input logic [9:0] count, input logic [9:0] len);
		logic [10:0] next_count;
		next_count = {1'b0, count} + 11'd1;
		return next_count >= {1'b0, len};
	endfunction

endpackage

`default_nettype wire

@@ sv/one_wire_bus_master_unit.sv @@
// One-wire bus master sequencer, stepped once per microsecond tick.
//
// Usage: every input transaction on in_valid/in_ready is one bus tick carrying
// the sampled line level and an optional command (bus reset, write byte, read
// byte). A command is taken only while the sequencer is idle and is ignored
// while busy. Each input transaction yields exactly one output transaction on
// out_valid/out_ready with drive_low, pullup_on, busy, done, presence and the
// last read byte for that tick.
// The result of a tick is registered: it is in the output register on the
// cycle after it is accepted. Throughput is one tick per cycle unless the
// receiver stalls; sequencer state and output register update on acceptance.
// When the receiver stalls, the output register holds its transaction and
// in_ready drops until it is taken, so no tick is lost or repeated.
// Configuration writes through cfg_we/cfg_index/cfg_data take effect at once;
// phase lengths are read live by the sequencer.
// Reset clears the sequencer to idle, presence and read byte to zero, and
// loads the default timing values (480, 14, 240, 60, 2, 5, 2 ticks).
`default_nettype none

module one_wire_bus_master_unit
	import owbm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CfgIndexW-1:0] cfg_index,
	input  wire logic [CfgDataW-1:0]  cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire owbm_in_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output owbm_out_t                 out_data
);

	// Timing registers.
	logic [9:0] reset_low_q;
	logic [7:0] response_wait_q;
	logic [9:0] presence_win_q;
	logic [7:0] slot_q;
	logic [3:0] start_q;
	logic [5:0] sample_delay_q;
	logic [3:0] recovery_q;

	// Sequencer state.
	phase_t     phase_q;
	logic [9:0] tick_q;
	logic [2:0] bit_q;
	logic [7:0] shift_q;
	logic       presence_q;
	logic [1:0] op_q;
	logic [7:0] read_hold_q;

	// Output register.
	logic      out_valid_q;
	owbm_out_t out_data_q;

	// Next-state values.
	phase_t     ph_d;
	logic [9:0] tick_d;
	logic [2:0] bit_d;
	logic [7:0] shift_d;
	logic       presence_d;
	logic [1:0] op_d;
	logic [7:0] read_hold_d;
	owbm_out_t  res_d;
	logic       moved;
	logic       accept;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_low_q     <= ResetLowDefault;
			response_wait_q <= ResponseWaitDefault;
			presence_win_q  <= PresenceWinDefault;
			slot_q          <= SlotDefault;
			start_q         <= StartDefault;
			sample_delay_q  <= SampleDelayDefault;
			recovery_q      <= RecoveryDefault;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RESET_LOW:     reset_low_q     <= cfg_data;
				CFG_RESPONSE_WAIT: response_wait_q <= cfg_data[7:0];
				CFG_PRESENCE_WIN:  presence_win_q  <= cfg_data;
				CFG_SLOT:          slot_q          <= cfg_data[7:0];
				CFG_START:         start_q         <= cfg_data[3:0];
				CFG_SAMPLE_DELAY:  sample_delay_q  <= cfg_data[5:0];
				CFG_RECOVERY:      recovery_q      <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// One tick of the bus sequencer.
	always_comb begin
		ph_d        = phase_q;
		tick_d      = tick_q;
		bit_d       = bit_q;
		shift_d     = shift_q;
		presence_d  = presence_q;
		op_d        = op_q;
		read_hold_d = read_hold_q;
		moved       = 1'b0;
		res_d       = '0;

		// A command starts an operation only from idle, on this same tick.
		if (phase_q == PH_IDLE && in_data.command != CMD_NONE) begin
			op_d   = in_data.command;
			tick_d = '0;
			bit_d  = '0;
			if (in_data.command == CMD_RESET) begin
				presence_d = 1'b0;
				ph_d       = PH_RST_LOW;
			end else begin
				shift_d = (in_data.command == CMD_WRITE) ? in_data.write_data : 8'd0;
				ph_d    = PH_SLOT_LOW;
			end
		end
		res_d.busy_res = (ph_d != PH_IDLE);

		unique case (ph_d)
			PH_IDLE: ;
			PH_RST_LOW: begin
				res_d.drive_low = 1'b1;
				res_d.pullup_on = 1'b1;
				if (at_end(tick_d, reset_low_q)) begin
					ph_d  = (response_wait_q != 8'd0) ? PH_RST_WAIT : PH_RST_WATCH;
					moved = 1'b1;
				end
			end
			PH_RST_WAIT: begin
				res_d.pullup_on = 1'b1;
				if (at_end(tick_d, {2'b00, response_wait_q})) begin
					ph_d  = PH_RST_WATCH;
					moved = 1'b1;
				end
			end
			PH_RST_WATCH: begin
				res_d.pullup_on = 1'b1;
				if (!in_data.line_level) begin
					presence_d = 1'b1;
					ph_d       = PH_RST_REC;
					moved      = 1'b1;
				end else if (at_end(tick_d, presence_win_q)) begin
					ph_d  = PH_RST_REC;
					moved = 1'b1;
				end
			end
			PH_RST_REC: begin
				if (at_end(tick_d, reset_low_q)) begin
					res_d.done_res = 1'b1;
					ph_d           = PH_IDLE;
					moved          = 1'b1;
				end
			end
			PH_SLOT_LOW: begin
				res_d.drive_low = 1'b1;
				if (at_end(tick_d, {6'd0, start_q})) begin
					ph_d  = (op_d == CMD_READ) ? PH_READ_WAIT : PH_SLOT_DATA;
					moved = 1'b1;
				end
			end
			PH_READ_WAIT: begin
				if (at_end(tick_d, {4'd0, sample_delay_q})) begin
					ph_d  = PH_SLOT_DATA;
					moved = 1'b1;
				end
			end
			PH_SLOT_DATA: begin
				// A read samples on the first data tick; a write drives the data bit.
				if (op_d == CMD_READ) begin
					if (tick_d == 10'd0) begin
						shift_d = {in_data.line_level, shift_d[7:1]};
					end
				end else begin
					res_d.drive_low = !shift_d[bit_d];
				end
				if (at_end(tick_d, {2'b00, slot_q})) begin
					ph_d  = PH_SLOT_REC;
					moved = 1'b1;
				end
			end
			PH_SLOT_REC: begin
				if (at_end(tick_d, {6'd0, recovery_q})) begin
					if (bit_d == 3'd7) begin
						res_d.done_res = 1'b1;
						if (op_d == CMD_READ) begin
							read_hold_d = shift_d;
						end
						bit_d = '0;
						ph_d  = PH_IDLE;
					end else begin
						bit_d = bit_d + 3'd1;
						ph_d  = PH_SLOT_LOW;
					end
					moved = 1'b1;
				end
			end
			default: ph_d = PH_IDLE;
		endcase

		// A phase change restarts the count; otherwise a running phase counts up.
		if (moved) begin
			tick_d = '0;
		end else if (ph_d != PH_IDLE) begin
			tick_d = tick_d + 10'd1;
		end

		res_d.presence  = presence_d;
		res_d.read_data = read_hold_d;
	end

	// Sequencer state advances once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			bit_q       <= '0;
			shift_q     <= '0;
			presence_q  <= 1'b0;
			op_q        <= '0;
			read_hold_q <= '0;
		end else if (accept) begin
			phase_q     <= ph_d;
			tick_q      <= tick_d;
			bit_q       <= bit_d;
			shift_q     <= shift_d;
			presence_q  <= presence_d;
			op_q        <= op_d;
			read_hold_q <= read_hold_d;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= res_d;
		end
	end

	// A finished operation is always reported as busy on its last tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.done_res |-> out_data_q.busy_res)
		else $error("done reported without busy");

	// An empty output register never holds back the input side.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output register");

	// The sequencer state moves only on an accepted tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(phase_q) && $stable(tick_q))
		else $error("sequencer advanced without a tick");

	// Starting a bus reset from idle clears the presence result and drives low.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_IDLE && in_data.command == CMD_RESET
		|=> !out_data_q.presence && out_data_q.drive_low)
		else $error("bus reset did not start cleanly");

	// The pull-up is only on during the reset phases.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.pullup_on |-> out_data_q.busy_res && op_q == CMD_RESET)
		else $error("pull-up enabled outside a bus reset");

endmodule

`default_nettype wire
